// File: sv/fdbw_pkg.sv
package fdbw_pkg;

  // field widths of the stream words
  localparam int COORD_W      = 8;
  localparam int FRAG_DEPTH_W = 24;
  localparam int CHAN_W       = 8;
  localparam int NUM_CHAN     = 4;
  localparam int IN_TDATA_W   = 72;
  localparam int OUT_TDATA_W  = 40;

  // y * width + x, 8-bit row times 9-bit width plus carry room
  localparam int LIN_W = 18;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int SIZE_W     = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_TEST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd4;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch the accepted input word
    logic clr_start;  // load clear walk bound, zero the walk counter
    logic clr_init;   // walk the whole store (power-up clear)
    logic clr_step;   // clear one entry, advance counter
    logic addr_en;    // register address and frame check
    logic rd_en;      // read both stores
    logic calc_en;    // depth compare and blend products
    logic commit;     // write stores, load fragment result
    logic emit_clr;   // load clear-done result
  } fdbw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_end;
    logic out_free;
  } fdbw_stat_t;

endpackage

// File: sv/fdbw_ctrl.sv
module fdbw_ctrl import fdbw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tuser,
  output logic       in_tready,
  input  fdbw_stat_t stat,
  output fdbw_cmd_t  cmd
);

  typedef enum logic [8:0] {
    ST_INIT      = 9'b000000001,
    ST_INIT_WALK = 9'b000000010,
    ST_IDLE      = 9'b000000100,
    ST_ADDR      = 9'b000001000,
    ST_READ      = 9'b000010000,
    ST_CALC      = 9'b000100000,
    ST_WRITE     = 9'b001000000,
    ST_CLEAR     = 9'b010000000,
    ST_CDONE     = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_INIT: begin
        cmd.clr_start = 1'b1;
        cmd.clr_init  = 1'b1;
        state_nxt     = ST_INIT_WALK;
      end
      ST_INIT_WALK: begin
        if (stat.clr_end) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.clr_step = 1'b1;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_tuser) begin
            cmd.clr_start = 1'b1;
            state_nxt     = ST_CLEAR;
          end else begin
            state_nxt = ST_ADDR;
          end
        end
      end
      ST_ADDR: begin
        cmd.addr_en = 1'b1;
        state_nxt   = ST_READ;
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc_en = 1'b1;
        state_nxt   = ST_WRITE;
      end
      ST_WRITE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (stat.clr_end) begin
          state_nxt = ST_CDONE;
        end else begin
          cmd.clr_step = 1'b1;
        end
      end
      ST_CDONE: begin
        if (stat.out_free) begin
          cmd.emit_clr = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

endmodule

// File: sv/fdbw_datapath.sv
module fdbw_datapath import fdbw_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int DEPTH_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fdbw_cmd_t              cmd,
  output fdbw_stat_t             stat,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser
);

  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int NW = $clog2(STORE_SIZE + 1);
  localparam int CW = (NW > LIN_W) ? NW : LIN_W;
  localparam int PROD_W = 2 * CHAN_W;

  // configuration
  logic              dte_r, mode_r, blend_r;
  logic [SIZE_W-1:0] fw_r, fh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dte_r   <= 1'b0;
      mode_r  <= 1'b0;
      blend_r <= 1'b0;
      fw_r    <= SIZE_RESET;
      fh_r    <= SIZE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEPTH_TEST:   dte_r   <= cfg_data[0];
        CFG_DEPTH_MODE:   mode_r  <= cfg_data[0];
        CFG_BLEND_ENABLE: blend_r <= cfg_data[0];
        CFG_FRAME_WIDTH:  fw_r    <= cfg_data;
        CFG_FRAME_HEIGHT: fh_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame size capped to the store geometry
  logic [SIZE_W-1:0] eff_w, eff_h;
  assign eff_w = (32'(fw_r) > 32'(MAX_WIDTH))  ? SIZE_W'(MAX_WIDTH)  : fw_r;
  assign eff_h = (32'(fh_r) > 32'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : fh_r;

  // input word
  logic [COORD_W-1:0]      x_r, y_r;
  logic [FRAG_DEPTH_W-1:0] fd_r;
  logic [CHAN_W-1:0]       src_r [NUM_CHAN];  // red, green, blue, alpha

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r  <= in_tdata[7:0];
      y_r  <= in_tdata[15:8];
      fd_r <= in_tdata[39:16];
      for (int i = 0; i < NUM_CHAN; i++) begin
        src_r[i] <= in_tdata[40 + CHAN_W*i +: CHAN_W];
      end
    end
  end

  // address and frame check
  logic [AW-1:0] addr_r;
  logic          oof_r;
  logic [CW-1:0] lin;
  assign lin = CW'(y_r) * CW'(eff_w) + CW'(x_r);

  always_ff @(posedge clk) begin
    if (cmd.addr_en) begin
      addr_r <= lin[AW-1:0];
      oof_r  <= ({1'b0, x_r} >= eff_w) || ({1'b0, y_r} >= eff_h);
    end
  end

  // clear walk
  logic [NW-1:0] cnt_r, n_r;
  logic [CW-1:0] area;
  assign area = CW'(eff_w) * CW'(eff_h);

  always_ff @(posedge clk) begin
    if (cmd.clr_start) begin
      cnt_r <= '0;
      n_r   <= cmd.clr_init ? NW'(STORE_SIZE) : area[NW-1:0];
    end else if (cmd.clr_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign stat.clr_end = (cnt_r == n_r);

  // stores
  logic [CHAN_W*NUM_CHAN-1:0] colour_mem [STORE_SIZE];
  logic [DEPTH_BITS-1:0]      depth_mem  [STORE_SIZE];
  logic [CHAN_W*NUM_CHAN-1:0] colour_q;
  logic [DEPTH_BITS-1:0]      depth_q;

  logic                       wr_ok, colour_we, depth_we;
  logic [AW-1:0]              wr_addr;
  logic [CHAN_W*NUM_CHAN-1:0] colour_wd, colour_new;
  logic [DEPTH_BITS-1:0]      depth_wd, nd;

  assign nd        = DEPTH_BITS'(fd_r);
  assign colour_we = cmd.clr_step || (cmd.commit && wr_ok);
  assign depth_we  = cmd.clr_step || (cmd.commit && wr_ok && dte_r);
  assign wr_addr   = cmd.clr_step ? cnt_r[AW-1:0] : addr_r;
  assign colour_wd = cmd.clr_step ? '0 : colour_new;
  assign depth_wd  = cmd.clr_step ? '1 : nd;

  always_ff @(posedge clk) begin
    if (colour_we) begin
      colour_mem[wr_addr] <= colour_wd;
    end
    if (cmd.rd_en) begin
      colour_q <= colour_mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (depth_we) begin
      depth_mem[wr_addr] <= depth_wd;
    end
    if (cmd.rd_en) begin
      depth_q <= depth_mem[addr_r];
    end
  end

  // depth compare and blend products
  logic              pass_r;
  logic [PROD_W-1:0] p_src_r [NUM_CHAN];
  logic [PROD_W-1:0] p_dst_r [NUM_CHAN];
  logic [CHAN_W-1:0] inv_a;
  assign inv_a = 8'd255 - src_r[3];

  always_ff @(posedge clk) begin
    if (cmd.calc_en) begin
      pass_r <= !dte_r || (mode_r ? (nd > depth_q) : (nd < depth_q));
      for (int i = 0; i < NUM_CHAN; i++) begin
        p_src_r[i] <= PROD_W'(src_r[i]) * PROD_W'(src_r[3]);
        p_dst_r[i] <= PROD_W'(colour_q[CHAN_W*i +: CHAN_W]) * PROD_W'(inv_a);
      end
    end
  end

  // sum / 255 via (v + 1 + (v >> 8)) >> 8, exact for v up to 255*255
  assign wr_ok = pass_r && !oof_r;

  always_comb begin
    logic [PROD_W:0] v;
    logic [PROD_W:0] t;
    colour_new = '0;
    for (int i = 0; i < NUM_CHAN; i++) begin
      v = {1'b0, p_src_r[i]} + {1'b0, p_dst_r[i]};
      t = v + (PROD_W+1)'(1) + (v >> 8);
      colour_new[CHAN_W*i +: CHAN_W] = blend_r ? t[15:8] : src_r[i];
    end
  end

  // result register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit || cmd.emit_clr) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= {6'b0, (wr_ok ? colour_new : '0), oof_r, wr_ok};
      out_user_r <= 1'b0;
    end else if (cmd.emit_clr) begin
      out_data_r <= '0;
      out_user_r <= 1'b1;
    end
  end

  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign out_tuser     = out_user_r;

endmodule

// File: sv/fragment_depth_blend_writer_unit.sv
// Flow: a fragment word steps through address, read, calc and write states, and its
//   result is registered on commit; a clear word clears width*height store entries,
//   one store entry per cycle, then gives clear_done. A new word is taken only in
//   idle, after the read-modify-write of the last one; results wait for out_tready.
// Reset (rst_n, synchronous, active low) clears config and control, then a clearing
//   pass over all MAX_WIDTH*MAX_HEIGHT entries runs before in_tready first rises.
module fragment_depth_blend_writer_unit import fdbw_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int DEPTH_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,

  // input word
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // pixel_x[7:0], pixel_y[15:8], frag_depth[39:16], src_red[47:40],
  // src_green[55:48], src_blue[63:56], src_alpha[71:64]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // kind[0]: 0 fragment, 1 clear
  input  logic                   in_tuser,

  // result word
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // written[0], out_of_frame[1], out_red[9:2], out_green[17:10],
  // out_blue[25:18], out_alpha[33:26], zero pad[39:34]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // clear_done[0]
  output logic                   out_tuser,

  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  fdbw_cmd_t  cmd;
  fdbw_stat_t stat;

  // registers take a write in any cycle; the host is to write only while idle
  assign cfg_ready = 1'b1;

  // sequencer: power-up clear, fragment steps addr/read/calc/write, clear walk
  fdbw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // config registers, both stores, blend arithmetic and the result register
  fdbw_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
